// ----- sv/kpi_pkg.sv -----
// ----------------------------------------------------------------------------
// kpi_pkg
// Fixed-point constants, types, micro-program and arithmetic helpers for the
// Kalman/PI throttle controller.
// ----------------------------------------------------------------------------
package kpi_pkg;

    localparam int FRAC_BITS = 40;

    typedef logic signed [63:0] t_fx;

    localparam t_fx FX_MAX  = {1'b0, {63{1'b1}}};
    localparam t_fx FX_MIN  = {1'b1, {63{1'b0}}};
    localparam t_fx FX_ZERO = '0;
    localparam t_fx FX_ONE  = t_fx'(64'd1 << FRAC_BITS);
    localparam t_fx FX_DT   = t_fx'(((64'd1 << FRAC_BITS) + 64'd50000) / 64'd100000);
    localparam t_fx FX_Q    = t_fx'(((64'd8 << FRAC_BITS) + 64'd5000) / 64'd10000);
    localparam t_fx FX_R    = t_fx'(((64'd18 << FRAC_BITS) + 64'd500) / 64'd1000);
    localparam t_fx FX_LOW  = t_fx'(((64'd3 << FRAC_BITS) + 64'd5) / 64'd10);
    localparam t_fx FX_HIGH = t_fx'(64'd100 << FRAC_BITS);
    localparam t_fx FX_DBLO = t_fx'(((64'd9 << FRAC_BITS) + 64'd5) / 64'd10);
    localparam t_fx FX_DBHI = t_fx'(((64'd11 << FRAC_BITS) + 64'd5) / 64'd10);
    localparam t_fx FX_200  = t_fx'(64'd200);

    localparam logic [19:0] MAX_SLEEP_RST = 20'd200000;
    localparam logic [15:0] GAIN_P_RST    = 16'd29491;
    localparam logic [15:0] GAIN_I_RST    = 16'd3604;
    localparam logic [15:0] SLEEP_SCALE   = 16'd55000;
    localparam logic [40:0] SLEEP_BASE    = 41'd5;

    localparam logic [1:0] REG_MAX_SLEEP = 2'd0;
    localparam logic [1:0] REG_GAIN_P    = 2'd1;
    localparam logic [1:0] REG_GAIN_I    = 2'd2;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_CLMP,
        OP_CLMI
    } t_op;

    typedef enum logic [4:0] {
        S_LEVEL, S_RATE, S_C00, S_C01, S_C10, S_C11, S_ZM, S_ZP,
        S_P00, S_P01, S_P10, S_P11, S_Y, S_S, S_K0, S_K1,
        S_T, S_T2, S_ERR, S_INT, S_DQ, S_Z,
        S_DT, S_Q, S_R, S_ONE, S_ZERO, S_C200, S_DEN, S_GP, S_GI
    } t_src;

    typedef struct packed {
        t_op  op;
        t_src a;
        t_src b;
        t_src dst;
    } t_uop;

    localparam logic [5:0] LAST_PC = 6'd39;

    function automatic t_uop uop_at(input logic [5:0] pc);
        t_uop u;
        u = '{OP_ADD, S_ZERO, S_ZERO, S_T};
        case (pc)
            6'd0:  u = '{OP_DIV,  S_C200,  S_DEN,  S_ZM};
            6'd1:  u = '{OP_CLMP, S_ZM,    S_ZERO, S_ZM};
            6'd2:  u = '{OP_MUL,  S_DT,    S_RATE, S_T};
            6'd3:  u = '{OP_ADD,  S_LEVEL, S_T,    S_ZP};
            6'd4:  u = '{OP_MUL,  S_DT,    S_C01,  S_T};
            6'd5:  u = '{OP_ADD,  S_C00,   S_T,    S_P00};
            6'd6:  u = '{OP_MUL,  S_DT,    S_C10,  S_T};
            6'd7:  u = '{OP_ADD,  S_P00,   S_T,    S_P00};
            6'd8:  u = '{OP_MUL,  S_DT,    S_C11,  S_T};
            6'd9:  u = '{OP_MUL,  S_DT,    S_T,    S_T};
            6'd10: u = '{OP_ADD,  S_P00,   S_T,    S_P00};
            6'd11: u = '{OP_ADD,  S_P00,   S_Q,    S_P00};
            6'd12: u = '{OP_MUL,  S_DT,    S_C11,  S_T};
            6'd13: u = '{OP_ADD,  S_C01,   S_T,    S_P01};
            6'd14: u = '{OP_ADD,  S_C10,   S_T,    S_P10};
            6'd15: u = '{OP_ADD,  S_C11,   S_Q,    S_P11};
            6'd16: u = '{OP_SUB,  S_ZM,    S_ZP,   S_Y};
            6'd17: u = '{OP_ADD,  S_P00,   S_R,    S_S};
            6'd18: u = '{OP_DIV,  S_P00,   S_S,    S_K0};
            6'd19: u = '{OP_DIV,  S_P10,   S_S,    S_K1};
            6'd20: u = '{OP_MUL,  S_K0,    S_Y,    S_T};
            6'd21: u = '{OP_ADD,  S_ZP,    S_T,    S_LEVEL};
            6'd22: u = '{OP_MUL,  S_K1,    S_Y,    S_T};
            6'd23: u = '{OP_ADD,  S_RATE,  S_T,    S_RATE};
            6'd24: u = '{OP_SUB,  S_ONE,   S_K0,   S_T};
            6'd25: u = '{OP_MUL,  S_T,     S_P00,  S_C00};
            6'd26: u = '{OP_MUL,  S_T,     S_P01,  S_C01};
            6'd27: u = '{OP_MUL,  S_K1,    S_P00,  S_T};
            6'd28: u = '{OP_SUB,  S_P10,   S_T,    S_C10};
            6'd29: u = '{OP_MUL,  S_K1,    S_P01,  S_T};
            6'd30: u = '{OP_SUB,  S_P11,   S_T,    S_C11};
            6'd31: u = '{OP_CLMP, S_LEVEL, S_ZERO, S_Z};
            6'd32: u = '{OP_SUB,  S_ONE,   S_Z,    S_ERR};
            6'd33: u = '{OP_MUL,  S_ERR,   S_DT,   S_T};
            6'd34: u = '{OP_ADD,  S_INT,   S_T,    S_T};
            6'd35: u = '{OP_CLMI, S_T,     S_ZERO, S_INT};
            6'd36: u = '{OP_MUL,  S_GP,    S_ERR,  S_T};
            6'd37: u = '{OP_MUL,  S_GI,    S_INT,  S_T2};
            6'd38: u = '{OP_ADD,  S_T,     S_T2,   S_DQ};
            6'd39: u = '{OP_SUB,  S_ZERO,  S_DQ,   S_DQ};
            default: u = '{OP_ADD, S_ZERO, S_ZERO, S_T};
        endcase
        return u;
    endfunction

    function automatic logic [63:0] mag(input t_fx x);
        return x[63] ? 64'(-x) : 64'(x);
    endfunction

    function automatic t_fx from_mag(input logic neg, input logic [63:0] m);
        if (!neg) begin
            return m[63] ? FX_MAX : t_fx'(m);
        end
        if (m[63]) begin
            return FX_MIN;
        end
        return -t_fx'(m);
    endfunction

    function automatic t_fx sat_add(input t_fx a, input t_fx b);
        t_fx s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63]) begin
            return a[63] ? FX_MIN : FX_MAX;
        end
        return s;
    endfunction

    function automatic t_fx sat_sub(input t_fx a, input t_fx b);
        t_fx s;
        s = a - b;
        if (a[63] != b[63] && s[63] != a[63]) begin
            return a[63] ? FX_MIN : FX_MAX;
        end
        return s;
    endfunction

    function automatic t_fx clamp(input t_fx x, input t_fx lo, input t_fx hi);
        if (x < lo) begin
            return lo;
        end
        if (x > hi) begin
            return hi;
        end
        return x;
    endfunction

endpackage

// ----- sv/kalman_pi_throttle_controller_core.sv -----
// ----------------------------------------------------------------------------
// kalman_pi_throttle_controller_core
// Pulse-rate load measure, two-state Kalman filter and PI throttle law.
// Each input beat runs three bit-serial divides, fifteen passes through the
// four-step 32x32 multiplier and 22 micro-ops that write back directly. A pulse
// difference of 1000 or more skips the load divide; a divide by zero or one that
// saturates is resolved without the bit-serial loop.
// The next input beat is taken once back in idle, even while the previous result
// beat still waits; a second result waits in the final step until the output frees.
// Synchronous active-low reset restores filter state, counter and registers.
// ----------------------------------------------------------------------------
module kalman_pi_throttle_controller_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    input  logic [63:0]   i_s_axis_tdata,   // [63:0] pulse_total
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    // [19:0] sleep_ns, [42:20] level_estimate, [82:43] rate_estimate,
    // [106:83] level_error, [138:107] correction_count, [143:139] zero
    output logic [143:0]  o_m_axis_tdata,
    input  logic          i_psel,
    input  logic          i_penable,
    input  logic          i_pwrite,
    input  logic [3:0]    i_paddr,
    input  logic [31:0]   i_pwdata,
    output logic [31:0]   o_prdata,
    output logic          o_pready
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_LOAD  = 8'b0000_0010,
        ST_EXEC  = 8'b0000_0100,
        ST_MUL   = 8'b0000_1000,
        ST_MULF  = 8'b0001_0000,
        ST_DIV   = 8'b0010_0000,
        ST_DEAD  = 8'b0100_0000,
        ST_SLEEP = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic [5:0]  r_pc;
    logic [63:0] r_pulse, r_prev;
    logic [19:0] r_max_sleep;
    logic [15:0] r_gain_p, r_gain_i;
    kpi_pkg::t_fx r_level, r_rate, r_c00, r_c01, r_c10, r_c11, r_int;
    kpi_pkg::t_fx r_zm, r_zp, r_p00, r_p01, r_p10, r_p11, r_y, r_s;
    kpi_pkg::t_fx r_k0, r_k1, r_t, r_t2, r_err, r_dq, r_z, r_den;
    kpi_pkg::t_src r_dst;
    logic [63:0]  r_ma, r_mb;
    logic         r_mneg;
    logic [127:0] r_acc;
    logic [1:0]   r_mcnt;
    logic [63:0]  r_rem, r_nlo, r_dd, r_q;
    logic [5:0]   r_dcnt;
    logic         r_dneg;
    logic [79:0]  r_prod;
    logic         r_pneg;
    logic         r_out_valid;
    logic [19:0]  r_o_sleep;
    logic [22:0]  r_o_level;
    logic [39:0]  r_o_rate;
    logic [23:0]  r_o_err;
    logic [31:0]  r_tick;

    kpi_pkg::t_uop uop;
    kpi_pkg::t_fx  a_val, b_val;
    logic          wb_en;
    kpi_pkg::t_src wb_dst;
    kpi_pkg::t_fx  wb_val;
    logic          advance;
    logic [63:0]   d_diff;
    logic [63:0]   div_ma, div_mb, div_hi;
    logic [63:0]   pp;
    logic [6:0]    pp_sh;
    logic [63:0]   mul_q;
    logic [63:0]   rem_sh, q_nxt;
    logic          div_take;
    kpi_pkg::t_fx  dq_eff;
    logic [79-kpi_pkg::FRAC_BITS:0] ip;
    logic [40:0]   ip_w, c_w, sleep_w;
    logic [19:0]   sleep_fin;
    logic          out_free, cfg_wr;
    kpi_pkg::t_fx  rate_sh;
    logic [39:0]   rate16;

    always_comb begin
        uop = kpi_pkg::uop_at(r_pc);
    end

    always_comb begin
        case (uop.a)
            kpi_pkg::S_LEVEL: a_val = r_level;
            kpi_pkg::S_RATE:  a_val = r_rate;
            kpi_pkg::S_C00:   a_val = r_c00;
            kpi_pkg::S_C01:   a_val = r_c01;
            kpi_pkg::S_C10:   a_val = r_c10;
            kpi_pkg::S_C11:   a_val = r_c11;
            kpi_pkg::S_ZM:    a_val = r_zm;
            kpi_pkg::S_ZP:    a_val = r_zp;
            kpi_pkg::S_P00:   a_val = r_p00;
            kpi_pkg::S_P01:   a_val = r_p01;
            kpi_pkg::S_P10:   a_val = r_p10;
            kpi_pkg::S_P11:   a_val = r_p11;
            kpi_pkg::S_Y:     a_val = r_y;
            kpi_pkg::S_S:     a_val = r_s;
            kpi_pkg::S_K0:    a_val = r_k0;
            kpi_pkg::S_K1:    a_val = r_k1;
            kpi_pkg::S_T:     a_val = r_t;
            kpi_pkg::S_T2:    a_val = r_t2;
            kpi_pkg::S_ERR:   a_val = r_err;
            kpi_pkg::S_INT:   a_val = r_int;
            kpi_pkg::S_DQ:    a_val = r_dq;
            kpi_pkg::S_Z:     a_val = r_z;
            kpi_pkg::S_DT:    a_val = kpi_pkg::FX_DT;
            kpi_pkg::S_Q:     a_val = kpi_pkg::FX_Q;
            kpi_pkg::S_R:     a_val = kpi_pkg::FX_R;
            kpi_pkg::S_ONE:   a_val = kpi_pkg::FX_ONE;
            kpi_pkg::S_C200:  a_val = kpi_pkg::FX_200;
            kpi_pkg::S_DEN:   a_val = r_den;
            kpi_pkg::S_GP:    a_val = kpi_pkg::t_fx'(64'(r_gain_p) << (kpi_pkg::FRAC_BITS - 16));
            kpi_pkg::S_GI:    a_val = kpi_pkg::t_fx'(64'(r_gain_i) << (kpi_pkg::FRAC_BITS - 16));
            default:          a_val = kpi_pkg::FX_ZERO;
        endcase
        case (uop.b)
            kpi_pkg::S_LEVEL: b_val = r_level;
            kpi_pkg::S_RATE:  b_val = r_rate;
            kpi_pkg::S_C00:   b_val = r_c00;
            kpi_pkg::S_C01:   b_val = r_c01;
            kpi_pkg::S_C10:   b_val = r_c10;
            kpi_pkg::S_C11:   b_val = r_c11;
            kpi_pkg::S_ZM:    b_val = r_zm;
            kpi_pkg::S_ZP:    b_val = r_zp;
            kpi_pkg::S_P00:   b_val = r_p00;
            kpi_pkg::S_P01:   b_val = r_p01;
            kpi_pkg::S_P10:   b_val = r_p10;
            kpi_pkg::S_P11:   b_val = r_p11;
            kpi_pkg::S_Y:     b_val = r_y;
            kpi_pkg::S_S:     b_val = r_s;
            kpi_pkg::S_K0:    b_val = r_k0;
            kpi_pkg::S_K1:    b_val = r_k1;
            kpi_pkg::S_T:     b_val = r_t;
            kpi_pkg::S_T2:    b_val = r_t2;
            kpi_pkg::S_ERR:   b_val = r_err;
            kpi_pkg::S_INT:   b_val = r_int;
            kpi_pkg::S_DQ:    b_val = r_dq;
            kpi_pkg::S_Z:     b_val = r_z;
            kpi_pkg::S_DT:    b_val = kpi_pkg::FX_DT;
            kpi_pkg::S_Q:     b_val = kpi_pkg::FX_Q;
            kpi_pkg::S_R:     b_val = kpi_pkg::FX_R;
            kpi_pkg::S_ONE:   b_val = kpi_pkg::FX_ONE;
            kpi_pkg::S_C200:  b_val = kpi_pkg::FX_200;
            kpi_pkg::S_DEN:   b_val = r_den;
            kpi_pkg::S_GP:    b_val = kpi_pkg::t_fx'(64'(r_gain_p) << (kpi_pkg::FRAC_BITS - 16));
            kpi_pkg::S_GI:    b_val = kpi_pkg::t_fx'(64'(r_gain_i) << (kpi_pkg::FRAC_BITS - 16));
            default:          b_val = kpi_pkg::FX_ZERO;
        endcase
    end

    // shared datapath: pulse difference, bit-serial divider, multiplier
    always_comb begin
        d_diff   = r_pulse - r_prev;
        div_ma   = kpi_pkg::mag(a_val);
        div_mb   = kpi_pkg::mag(b_val);
        div_hi   = div_ma >> (64 - kpi_pkg::FRAC_BITS);
        pp       = r_ma[32*r_mcnt[1] +: 32] * r_mb[32*r_mcnt[0] +: 32];
        pp_sh    = {({1'b0, r_mcnt[1]} + {1'b0, r_mcnt[0]}), 5'd0};
        mul_q    = r_acc[kpi_pkg::FRAC_BITS +: 64];
        if (|r_acc[127:kpi_pkg::FRAC_BITS+64]) begin
            mul_q = '1;
        end
        rem_sh   = {r_rem[62:0], r_nlo[63]};
        div_take = r_rem[63] || (rem_sh >= r_dd);
        q_nxt    = {r_q[62:0], div_take};
    end

    always_comb begin
        n_state = r_state;
        wb_en   = 1'b0;
        wb_dst  = uop.dst;
        wb_val  = kpi_pkg::FX_ZERO;
        advance = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                n_state = ST_EXEC;
            end
            ST_EXEC: begin
                case (uop.op)
                    kpi_pkg::OP_ADD: begin
                        wb_en = 1'b1;
                        wb_val = kpi_pkg::sat_add(a_val, b_val);
                        advance = 1'b1;
                    end
                    kpi_pkg::OP_SUB: begin
                        wb_en = 1'b1;
                        wb_val = kpi_pkg::sat_sub(a_val, b_val);
                        advance = 1'b1;
                    end
                    kpi_pkg::OP_CLMP: begin
                        wb_en = 1'b1;
                        wb_val = kpi_pkg::clamp(a_val, kpi_pkg::FX_LOW, kpi_pkg::FX_HIGH);
                        advance = 1'b1;
                    end
                    kpi_pkg::OP_CLMI: begin
                        wb_en = 1'b1;
                        wb_val = kpi_pkg::clamp(a_val, -kpi_pkg::FX_ONE, kpi_pkg::FX_ONE);
                        advance = 1'b1;
                    end
                    kpi_pkg::OP_MUL: begin
                        n_state = ST_MUL;
                    end
                    kpi_pkg::OP_DIV: begin
                        if (b_val == kpi_pkg::FX_ZERO) begin
                            wb_en = 1'b1;
                            wb_val = (a_val == kpi_pkg::FX_ZERO) ? kpi_pkg::FX_ZERO :
                                     (a_val[63] ? kpi_pkg::FX_MIN : kpi_pkg::FX_MAX);
                            advance = 1'b1;
                        end else if (div_hi >= div_mb) begin
                            wb_en = 1'b1;
                            wb_val = kpi_pkg::from_mag(a_val[63] ^ b_val[63], '1);
                            advance = 1'b1;
                        end else begin
                            n_state = ST_DIV;
                        end
                    end
                    default: begin
                        advance = 1'b1;
                    end
                endcase
            end
            ST_MUL: begin
                if (r_mcnt == 2'd3) begin
                    n_state = ST_MULF;
                end
            end
            ST_MULF: begin
                wb_en = 1'b1;
                wb_dst = r_dst;
                wb_val = kpi_pkg::from_mag(r_mneg, mul_q);
                advance = 1'b1;
            end
            ST_DIV: begin
                if (r_dcnt == 6'd63) begin
                    wb_en = 1'b1;
                    wb_dst = r_dst;
                    wb_val = kpi_pkg::from_mag(r_dneg, q_nxt);
                    advance = 1'b1;
                end
            end
            ST_DEAD: begin
                n_state = ST_SLEEP;
            end
            ST_SLEEP: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (advance) begin
            n_state = (r_pc == kpi_pkg::LAST_PC) ? ST_DEAD : ST_EXEC;
        end
    end

    // sleep value and output formatting
    always_comb begin
        out_free = !r_out_valid || i_m_axis_tready;
        dq_eff   = (r_z > kpi_pkg::FX_DBLO && r_z < kpi_pkg::FX_DBHI) ? kpi_pkg::FX_ZERO : r_dq;
        ip       = r_prod[79:kpi_pkg::FRAC_BITS];
        ip_w     = 41'(ip);
        c_w      = ip_w + 41'(|r_prod[kpi_pkg::FRAC_BITS-1:0]);
        if (!r_pneg) begin
            sleep_w = kpi_pkg::SLEEP_BASE + ip_w;
        end else begin
            sleep_w = (c_w >= kpi_pkg::SLEEP_BASE) ? 41'd0 : kpi_pkg::SLEEP_BASE - c_w;
        end
        sleep_fin = (sleep_w > 41'(r_max_sleep)) ? r_max_sleep : sleep_w[19:0];
        rate_sh   = r_rate >>> (kpi_pkg::FRAC_BITS - 16);
        if (rate_sh > kpi_pkg::t_fx'(64'h0000_007F_FFFF_FFFF)) begin
            rate16 = 40'h7F_FFFF_FFFF;
        end else if (rate_sh < -kpi_pkg::t_fx'(64'h0000_0080_0000_0000)) begin
            rate16 = 40'h80_0000_0000;
        end else begin
            rate16 = rate_sh[39:0];
        end
    end

    assign cfg_wr = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pc        <= '0;
            r_prev      <= '0;
            r_level     <= kpi_pkg::FX_ONE;
            r_rate      <= '0;
            r_c00       <= kpi_pkg::FX_ONE;
            r_c01       <= '0;
            r_c10       <= '0;
            r_c11       <= kpi_pkg::FX_ONE;
            r_int       <= '0;
            r_tick      <= '0;
            r_out_valid <= 1'b0;
            r_max_sleep <= kpi_pkg::MAX_SLEEP_RST;
            r_gain_p    <= kpi_pkg::GAIN_P_RST;
            r_gain_i    <= kpi_pkg::GAIN_I_RST;
        end else begin
            r_state <= n_state;
            if (cfg_wr) begin
                case (i_paddr[3:2])
                    kpi_pkg::REG_MAX_SLEEP: r_max_sleep <= i_pwdata[19:0];
                    kpi_pkg::REG_GAIN_P:    r_gain_p <= i_pwdata[15:0];
                    kpi_pkg::REG_GAIN_I:    r_gain_i <= i_pwdata[15:0];
                    default: ;
                endcase
            end
            if (r_state == ST_IDLE && i_s_axis_tvalid) begin
                r_pulse <= i_s_axis_tdata;
            end
            if (r_state == ST_LOAD) begin
                r_prev <= r_pulse;
                r_den  <= kpi_pkg::t_fx'({d_diff[9:0], 3'd0} + {3'd0, d_diff[9:0], 1'b0} + 14'd1);
                if (d_diff < 64'd1000) begin
                    r_pc <= '0;
                end else begin
                    r_pc <= 6'd1;
                    r_zm <= kpi_pkg::FX_LOW;
                end
            end
            if (advance) begin
                r_pc <= r_pc + 6'd1;
            end
            if (r_state == ST_EXEC) begin
                r_dst  <= uop.dst;
                r_ma   <= kpi_pkg::mag(a_val);
                r_mb   <= kpi_pkg::mag(b_val);
                r_mneg <= a_val[63] ^ b_val[63];
                r_acc  <= '0;
                r_mcnt <= '0;
                r_rem  <= div_hi;
                r_nlo  <= div_ma << kpi_pkg::FRAC_BITS;
                r_dd   <= div_mb;
                r_q    <= '0;
                r_dcnt <= '0;
                r_dneg <= a_val[63] ^ b_val[63];
            end
            if (r_state == ST_MUL) begin
                r_acc  <= r_acc + ({64'd0, pp} << pp_sh);
                r_mcnt <= r_mcnt + 2'd1;
            end
            if (r_state == ST_DIV) begin
                r_rem  <= div_take ? rem_sh - r_dd : rem_sh;
                r_nlo  <= {r_nlo[62:0], 1'b0};
                r_q    <= q_nxt;
                r_dcnt <= r_dcnt + 6'd1;
            end
            if (wb_en) begin
                case (wb_dst)
                    kpi_pkg::S_LEVEL: r_level <= wb_val;
                    kpi_pkg::S_RATE:  r_rate <= wb_val;
                    kpi_pkg::S_C00:   r_c00 <= wb_val;
                    kpi_pkg::S_C01:   r_c01 <= wb_val;
                    kpi_pkg::S_C10:   r_c10 <= wb_val;
                    kpi_pkg::S_C11:   r_c11 <= wb_val;
                    kpi_pkg::S_ZM:    r_zm <= wb_val;
                    kpi_pkg::S_ZP:    r_zp <= wb_val;
                    kpi_pkg::S_P00:   r_p00 <= wb_val;
                    kpi_pkg::S_P01:   r_p01 <= wb_val;
                    kpi_pkg::S_P10:   r_p10 <= wb_val;
                    kpi_pkg::S_P11:   r_p11 <= wb_val;
                    kpi_pkg::S_Y:     r_y <= wb_val;
                    kpi_pkg::S_S:     r_s <= wb_val;
                    kpi_pkg::S_K0:    r_k0 <= wb_val;
                    kpi_pkg::S_K1:    r_k1 <= wb_val;
                    kpi_pkg::S_T:     r_t <= wb_val;
                    kpi_pkg::S_T2:    r_t2 <= wb_val;
                    kpi_pkg::S_ERR:   r_err <= wb_val;
                    kpi_pkg::S_INT:   r_int <= wb_val;
                    kpi_pkg::S_DQ:    r_dq <= wb_val;
                    kpi_pkg::S_Z:     r_z <= wb_val;
                    default: ;
                endcase
            end
            if (r_state == ST_DEAD) begin
                r_pneg <= dq_eff[63];
                r_prod <= kpi_pkg::mag(dq_eff) * kpi_pkg::SLEEP_SCALE;
            end
            if (r_state == ST_SLEEP && out_free) begin
                r_out_valid <= 1'b1;
                r_o_sleep   <= sleep_fin;
                r_o_level   <= r_z[kpi_pkg::FRAC_BITS-16 +: 23];
                r_o_rate    <= rate16;
                r_o_err     <= r_err[kpi_pkg::FRAC_BITS-16 +: 24];
                if (sleep_fin > 20'd5) begin
                    r_tick <= r_tick + 32'd1;
                end
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        case (i_paddr[3:2])
            kpi_pkg::REG_MAX_SLEEP: o_prdata = {12'd0, r_max_sleep};
            kpi_pkg::REG_GAIN_P:    o_prdata = {16'd0, r_gain_p};
            kpi_pkg::REG_GAIN_I:    o_prdata = {16'd0, r_gain_i};
            default:                o_prdata = '0;
        endcase
    end

    assign o_pready        = 1'b1;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'd0, r_tick, r_o_err, r_o_rate, r_o_level, r_o_sleep};

`ifndef SYNTHESIS
    a_int_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_int <= kpi_pkg::FX_ONE) && (r_int >= -kpi_pkg::FX_ONE))
        else $error("error integral outside unit range");
    a_sleep_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_o_sleep <= r_max_sleep))
        else $error("sleep beat exceeds max_sleep");
    a_valid_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_SLEEP))
        else $error("result beat raised outside final step");
    a_tick_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tick != $past(r_tick)) |-> $past(r_state == ST_SLEEP))
        else $error("correction count moved without a result beat");
`endif

endmodule
